// File: rtl/core/prim_asm_pkg.sv
// ----------------------------------------------------------------------------
// prim_asm_pkg
// Shared types, codes and widths of the primitive assembler.
// ----------------------------------------------------------------------------
package prim_asm_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

    // fixed field widths
    localparam int OPCODE_W = 2;
    localparam int MODE_W   = 3;
    localparam int VERT_W   = 16;
    localparam int SCALE_W  = 16;
    localparam int OFFSET_W = 24;
    localparam int COLOR_W  = 24;
    localparam int LWIDTH_W = 8;
    localparam int PT_W     = 16;

    localparam int STORE_DEPTH = 4;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_COLOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 3'd5;

    localparam logic signed [SCALE_W-1:0]  SCALE_RESET  = 16'sd256;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 24'sd0;
    localparam logic [COLOR_W-1:0]         COLOR_RESET  = 24'd0;
    localparam logic [LWIDTH_W-1:0]        LWIDTH_RESET = 8'd1;

    // input opcodes
    localparam logic [OPCODE_W-1:0] OPCODE_BEGIN  = 2'd0;
    localparam logic [OPCODE_W-1:0] OPCODE_VERTEX = 2'd1;
    localparam logic [OPCODE_W-1:0] OPCODE_END    = 2'd2;

    // result kinds
    localparam logic PRIM_LINE = 1'b0;
    localparam logic PRIM_QUAD = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE   = 3'd0,
        MODE_LINES  = 3'd1,
        MODE_STRIP  = 3'd2,
        MODE_LOOP   = 3'd3,
        MODE_QUADS  = 3'd4,
        MODE_QSTRIP = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_VERTEX = 2'd1,
        CMD_END    = 2'd2
    } cmd_kind_t;

    // control part of a queued command
    typedef struct packed {
        cmd_kind_t kind;
        mode_t     mode;
    } q_ctrl_t;

endpackage

// File: rtl/core/prim_asm_ifs.sv
// ----------------------------------------------------------------------------
// prim_asm channel interfaces
// Command channel into the assembler and primitive channel out of it.
// ----------------------------------------------------------------------------
interface prim_asm_cmd_if;
    import prim_asm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [MODE_W-1:0]          prim_mode;
    logic signed [VERT_W-1:0]   vert_x;
    logic signed [VERT_W-1:0]   vert_y;

    modport source (output valid, output opcode, output prim_mode, output vert_x,
                    output vert_y, input ready);
    modport sink   (input valid, input opcode, input prim_mode, input vert_x,
                    input vert_y, output ready);
endinterface

interface prim_asm_prim_if;
    import prim_asm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     prim_kind;
    logic signed [PT_W-1:0]   pt0_x;
    logic signed [PT_W-1:0]   pt0_y;
    logic signed [PT_W-1:0]   pt1_x;
    logic signed [PT_W-1:0]   pt1_y;
    logic signed [PT_W-1:0]   pt2_x;
    logic signed [PT_W-1:0]   pt2_y;
    logic signed [PT_W-1:0]   pt3_x;
    logic signed [PT_W-1:0]   pt3_y;
    logic [COLOR_W-1:0]       out_color;
    logic [LWIDTH_W-1:0]      out_width;

    modport source (output valid, output prim_kind, output pt0_x, output pt0_y,
                    output pt1_x, output pt1_y, output pt2_x, output pt2_y,
                    output pt3_x, output pt3_y, output out_color, output out_width,
                    input ready);
    modport sink   (input valid, input prim_kind, input pt0_x, input pt0_y,
                    input pt1_x, input pt1_y, input pt2_x, input pt2_y,
                    input pt3_x, input pt3_y, input out_color, input out_width,
                    output ready);
endinterface

// File: rtl/core/prim_asm_front.sv
// ----------------------------------------------------------------------------
// prim_asm_front
// Accepts command items, decodes them and transforms vertex coordinates.
// ----------------------------------------------------------------------------
module prim_asm_front #(
    parameter int COORD_BITS = prim_asm_pkg::COORD_BITS_DEFAULT,
    parameter int ENTRY_W    = $bits(prim_asm_pkg::q_ctrl_t) + 2 * COORD_BITS
) (
    prim_asm_cmd_if.sink                                cmd,
    input  logic signed [prim_asm_pkg::SCALE_W-1:0]     scale_x,
    input  logic signed [prim_asm_pkg::SCALE_W-1:0]     scale_y,
    input  logic signed [prim_asm_pkg::OFFSET_W-1:0]    offset_x,
    input  logic signed [prim_asm_pkg::OFFSET_W-1:0]    offset_y,
    input  logic                                        q_full,
    output logic                                        push,
    output logic [ENTRY_W-1:0]                          push_entry
);
    import prim_asm_pkg::*;

    localparam int ACC_W = 32;
    localparam int Q_W   = 24;
    localparam int SAT_W = 34;
    localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (COORD_BITS - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // x * scale + offset in Q.8, truncated toward zero, saturated
    function automatic logic signed [COORD_BITS-1:0] xform(
        input logic signed [VERT_W-1:0]   c,
        input logic signed [SCALE_W-1:0]  s,
        input logic signed [OFFSET_W-1:0] o
    );
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] biased;
        logic signed [Q_W-1:0]   q;
        logic signed [SAT_W-1:0] qw;
        prod   = ACC_W'(c) * ACC_W'(s);
        acc    = prod + ACC_W'(o);
        // bias negatives so the arithmetic shift rounds toward zero
        biased = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
        q      = Q_W'(biased >>> 8);
        qw     = SAT_W'(q);
        if (qw > SAT_HI)
        begin
            qw = SAT_HI;
        end
        if (qw < SAT_LO)
        begin
            qw = SAT_LO;
        end
        return qw[COORD_BITS-1:0];
    endfunction

    q_ctrl_t                        ctrl;
    logic signed [COORD_BITS-1:0]   tx;
    logic signed [COORD_BITS-1:0]   ty;
    logic                           known_op;

    assign cmd.ready = !q_full;
    assign tx = xform(cmd.vert_x, scale_x, offset_x);
    assign ty = xform(cmd.vert_y, scale_y, offset_y);

    always_comb
    begin
        known_op  = 1'b1;
        ctrl.kind = CMD_VERTEX;
        ctrl.mode = MODE_NONE;
        unique case (cmd.opcode)
            OPCODE_BEGIN:
            begin
                ctrl.kind = CMD_BEGIN;
                if (cmd.prim_mode <= MODE_QSTRIP)
                begin
                    ctrl.mode = mode_t'(cmd.prim_mode);
                end
            end
            OPCODE_VERTEX: ctrl.kind = CMD_VERTEX;
            OPCODE_END:    ctrl.kind = CMD_END;
            // reserved opcode is taken and dropped
            default:       known_op = 1'b0;
        endcase
    end

    assign push       = cmd.valid && !q_full && known_op;
    assign push_entry = {ctrl, tx, ty};

endmodule

// File: rtl/core/prim_asm_queue.sv
// ----------------------------------------------------------------------------
// prim_asm_queue
// Short first-in first-out queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module prim_asm_queue #(
    parameter int DEPTH = prim_asm_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("item pushed into a full command queue");

endmodule

// File: rtl/core/prim_asm_back.sv
// ----------------------------------------------------------------------------
// prim_asm_back
// Holds mode and vertex store, assembles lines and quads, drives the result.
// ----------------------------------------------------------------------------
module prim_asm_back #(
    parameter int COORD_BITS = prim_asm_pkg::COORD_BITS_DEFAULT,
    parameter int ENTRY_W    = $bits(prim_asm_pkg::q_ctrl_t) + 2 * COORD_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  logic [ENTRY_W-1:0]                      q_entry,
    output logic                                    q_pop,
    input  logic [prim_asm_pkg::COLOR_W-1:0]        draw_color,
    input  logic [prim_asm_pkg::LWIDTH_W-1:0]       line_width,
    prim_asm_prim_if.source                         prim
);
    import prim_asm_pkg::*;

    localparam int EXT_W = (COORD_BITS > PT_W) ? COORD_BITS : PT_W;
    localparam int HELD_W = 3;

    function automatic logic [PT_W-1:0] to_pt(input logic signed [COORD_BITS-1:0] v);
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[PT_W-1:0];
    endfunction

    q_ctrl_t                        ctrl;
    logic signed [COORD_BITS-1:0]   vx;
    logic signed [COORD_BITS-1:0]   vy;

    mode_t                          mode_reg;
    mode_t                          mode_next;
    logic [HELD_W-1:0]              held_reg;
    logic [HELD_W-1:0]              held_next;
    logic [HELD_W-1:0]              held_inc;
    logic [STORE_IDX_W-1:0]         wr_idx;

    logic signed [COORD_BITS-1:0]   sx_reg  [STORE_DEPTH];
    logic signed [COORD_BITS-1:0]   sy_reg  [STORE_DEPTH];
    logic signed [COORD_BITS-1:0]   sx_next [STORE_DEPTH];
    logic signed [COORD_BITS-1:0]   sy_next [STORE_DEPTH];
    logic signed [COORD_BITS-1:0]   view_x  [STORE_DEPTH];
    logic signed [COORD_BITS-1:0]   view_y  [STORE_DEPTH];

    logic                           emit;
    logic                           kind_sel;
    logic [PT_W-1:0]                sel_x [4];
    logic [PT_W-1:0]                sel_y [4];

    logic                           out_valid_reg;
    logic                           kind_reg;
    logic [PT_W-1:0]                pt_x_reg [4];
    logic [PT_W-1:0]                pt_y_reg [4];
    logic [COLOR_W-1:0]             color_reg;
    logic [LWIDTH_W-1:0]            width_reg;

    assign {ctrl, vx, vy} = q_entry;
    assign q_pop  = q_valid && (!out_valid_reg || prim.ready);
    assign wr_idx = held_reg[STORE_IDX_W-1:0];
    assign held_inc = held_reg + HELD_W'(1);

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        view_x    = sx_reg;
        view_y    = sy_reg;
        emit      = 1'b0;
        kind_sel  = PRIM_LINE;
        for (int i = 0; i < 4; i++)
        begin
            sel_x[i] = '0;
            sel_y[i] = '0;
        end

        unique case (ctrl.kind)
            CMD_BEGIN:
            begin
                mode_next = ctrl.mode;
                held_next = '0;
            end
            CMD_END:
            begin
                // loop closes from the last vertex back to the first
                if (mode_reg == MODE_LOOP && held_reg == HELD_W'(2))
                begin
                    emit     = 1'b1;
                    sel_x[0] = to_pt(sx_reg[1]);
                    sel_y[0] = to_pt(sy_reg[1]);
                    sel_x[1] = to_pt(sx_reg[0]);
                    sel_y[1] = to_pt(sy_reg[0]);
                end
                mode_next = MODE_NONE;
                held_next = '0;
            end
            CMD_VERTEX:
            begin
                if (mode_reg != MODE_NONE)
                begin
                    sx_next[wr_idx] = vx;
                    sy_next[wr_idx] = vy;
                    view_x[wr_idx]  = vx;
                    view_y[wr_idx]  = vy;
                    held_next       = held_inc;
                    unique case (mode_reg)
                        MODE_LINES:
                        begin
                            if (held_inc == HELD_W'(2))
                            begin
                                emit      = 1'b1;
                                held_next = '0;
                            end
                        end
                        MODE_STRIP:
                        begin
                            if (held_inc == HELD_W'(2))
                            begin
                                emit       = 1'b1;
                                sx_next[0] = view_x[1];
                                sy_next[0] = view_y[1];
                                held_next  = HELD_W'(1);
                            end
                        end
                        MODE_LOOP:
                        begin
                            if (held_inc == HELD_W'(2))
                            begin
                                emit = 1'b1;
                            end
                            else if (held_inc == HELD_W'(3))
                            begin
                                emit       = 1'b1;
                                sx_next[1] = view_x[2];
                                sy_next[1] = view_y[2];
                                held_next  = HELD_W'(2);
                            end
                        end
                        MODE_QUADS:
                        begin
                            if (held_inc == HELD_W'(4))
                            begin
                                emit      = 1'b1;
                                kind_sel  = PRIM_QUAD;
                                held_next = '0;
                            end
                        end
                        MODE_QSTRIP:
                        begin
                            if (held_inc == HELD_W'(4))
                            begin
                                emit       = 1'b1;
                                kind_sel   = PRIM_QUAD;
                                sx_next[0] = view_x[2];
                                sy_next[0] = view_y[2];
                                sx_next[1] = view_x[3];
                                sy_next[1] = view_y[3];
                                held_next  = HELD_W'(2);
                            end
                        end
                        default: ;
                    endcase

                    // point selection for vertex-triggered results
                    if (mode_reg == MODE_LOOP && held_inc == HELD_W'(3))
                    begin
                        sel_x[0] = to_pt(view_x[1]);
                        sel_y[0] = to_pt(view_y[1]);
                        sel_x[1] = to_pt(view_x[2]);
                        sel_y[1] = to_pt(view_y[2]);
                    end
                    else
                    begin
                        sel_x[0] = to_pt(view_x[0]);
                        sel_y[0] = to_pt(view_y[0]);
                        sel_x[1] = to_pt(view_x[1]);
                        sel_y[1] = to_pt(view_y[1]);
                    end
                    if (kind_sel == PRIM_QUAD)
                    begin
                        // quad strip takes the second pair in reverse
                        if (mode_reg == MODE_QSTRIP)
                        begin
                            sel_x[2] = to_pt(view_x[3]);
                            sel_y[2] = to_pt(view_y[3]);
                            sel_x[3] = to_pt(view_x[2]);
                            sel_y[3] = to_pt(view_y[2]);
                        end
                        else
                        begin
                            sel_x[2] = to_pt(view_x[2]);
                            sel_y[2] = to_pt(view_y[2]);
                            sel_x[3] = to_pt(view_x[3]);
                            sel_y[3] = to_pt(view_y[3]);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
            end
            if (q_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (prim.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // vertex store and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (q_pop && emit)
        begin
            kind_reg  <= kind_sel;
            pt_x_reg  <= sel_x;
            pt_y_reg  <= sel_y;
            color_reg <= draw_color;
            width_reg <= (line_width == '0) ? LWIDTH_W'(1) : line_width;
        end
    end

    assign prim.valid     = out_valid_reg;
    assign prim.prim_kind = kind_reg;
    assign prim.pt0_x     = pt_x_reg[0];
    assign prim.pt0_y     = pt_y_reg[0];
    assign prim.pt1_x     = pt_x_reg[1];
    assign prim.pt1_y     = pt_y_reg[1];
    assign prim.pt2_x     = pt_x_reg[2];
    assign prim.pt2_y     = pt_y_reg[2];
    assign prim.pt3_x     = pt_x_reg[3];
    assign prim.pt3_y     = pt_y_reg[3];
    assign prim.out_color = color_reg;
    assign prim.out_width = width_reg;

    a_held_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != '0 |-> mode_reg != MODE_NONE)
        else $error("vertices held with no primitive open");

    a_line_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_LINES || mode_reg == MODE_STRIP) |-> held_reg <= HELD_W'(1))
        else $error("line or strip mode holds more than one vertex");

    a_quad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && ctrl.kind == CMD_VERTEX && mode_reg == MODE_QUADS
            && held_reg == HELD_W'(3))
        |=> (out_valid_reg && kind_reg == PRIM_QUAD))
        else $error("fourth quad vertex gave no quad");

endmodule

// File: rtl/core/primitive_assembler.sv
// ----------------------------------------------------------------------------
// primitive_assembler
// Takes one command item per cycle while the queue has room (begin, vertex or
// end) and returns at most one line or quad item per command. Vertices are
// scaled and offset in Q.8 fixed point, truncated toward zero and saturated
// to COORD_BITS before assembly. A decode and transform stage feeds a
// two-entry command queue; the assembly stage drains it into a single output
// register, so a new item is taken every cycle as long as results are taken,
// and a stalled result holds the assembly stage while the queue absorbs up to
// two more items. An accepted item is queued, then its result registered.
// Configuration writes are taken at any edge but must only be issued while
// no items are in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module primitive_assembler #(
    parameter int COORD_BITS = prim_asm_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    prim_asm_cmd_if.sink                            cmd,
    prim_asm_prim_if.source                         prim,
    input  logic                                    cfg_we,
    input  logic [prim_asm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prim_asm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import prim_asm_pkg::*;

    localparam int ENTRY_W = $bits(q_ctrl_t) + 2 * COORD_BITS;

    logic signed [SCALE_W-1:0]  scale_x_reg;
    logic signed [SCALE_W-1:0]  scale_y_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg;
    logic signed [OFFSET_W-1:0] offset_y_reg;
    logic [COLOR_W-1:0]         color_reg;
    logic [LWIDTH_W-1:0]        lwidth_reg;

    logic                       push;
    logic [ENTRY_W-1:0]         push_entry;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    logic [ENTRY_W-1:0]         q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg  <= SCALE_RESET;
            scale_y_reg  <= SCALE_RESET;
            offset_x_reg <= OFFSET_RESET;
            offset_y_reg <= OFFSET_RESET;
            color_reg    <= COLOR_RESET;
            lwidth_reg   <= LWIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE_X:    scale_x_reg  <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:    scale_y_reg  <= cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X:   offset_x_reg <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_Y:   offset_y_reg <= cfg_data[OFFSET_W-1:0];
                CFG_DRAW_COLOR: color_reg    <= cfg_data[COLOR_W-1:0];
                CFG_LINE_WIDTH: lwidth_reg   <= cfg_data[LWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    prim_asm_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .cmd        (cmd),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    prim_asm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_entry)
    );

    prim_asm_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .draw_color (color_reg),
        .line_width (lwidth_reg),
        .prim       (prim)
    );

endmodule
